@@ src/mtfkt_pkg.sv @@
package mtfkt_pkg;

  typedef enum logic [1:0] {
    REQ_APPEND = 2'd0,
    REQ_SEARCH = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_BAD_POS   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_SCAN,
    S_SHIFT,
    S_READ,
    S_READ_WAIT,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    append;
    logic    set_status;
    status_t status_code;
    logic    scan_init;
    logic    scan_run;
    logic    hit_take;
    logic    shift_run;
    logic    front_write;
    logic    read_issue;
    logic    read_take;
    logic    out_load;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;
    logic pos_ok;
    logic scan_hit;
    logic scan_miss;
    logic hit_front;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

@@ src/mtfkt_ctrl.sv @@
module mtfkt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          req_type,
  output logic                in_stall,
  input  mtfkt_pkg::sts_t     sts,
  output mtfkt_pkg::cmd_t     cmd
);

  mtfkt_pkg::state_t state;
  mtfkt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtfkt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      mtfkt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          unique case (mtfkt_pkg::req_t'(req_type))
            mtfkt_pkg::REQ_APPEND: state_next = mtfkt_pkg::S_APPEND;
            mtfkt_pkg::REQ_SEARCH: begin
              cmd.scan_init = 1'b1;
              state_next    = mtfkt_pkg::S_SCAN;
            end
            mtfkt_pkg::REQ_READ:   state_next = mtfkt_pkg::S_READ;
            default:               state_next = mtfkt_pkg::S_RESP;
          endcase
        end
      end
      mtfkt_pkg::S_APPEND: begin
        if (sts.full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = mtfkt_pkg::STS_FULL;
        end else begin
          cmd.append = 1'b1;
        end
        state_next = mtfkt_pkg::S_RESP;
      end
      mtfkt_pkg::S_SCAN: begin
        priority if (sts.scan_hit) begin
          cmd.hit_take = 1'b1;
          state_next   = sts.hit_front ? mtfkt_pkg::S_RESP : mtfkt_pkg::S_SHIFT;
        end else if (sts.scan_miss) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = mtfkt_pkg::STS_NOT_FOUND;
          state_next      = mtfkt_pkg::S_RESP;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      mtfkt_pkg::S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.front_write = 1'b1;
          state_next      = mtfkt_pkg::S_RESP;
        end else begin
          cmd.shift_run = 1'b1;
        end
      end
      mtfkt_pkg::S_READ: begin
        if (sts.pos_ok) begin
          cmd.read_issue = 1'b1;
          state_next     = mtfkt_pkg::S_READ_WAIT;
        end else begin
          cmd.set_status  = 1'b1;
          cmd.status_code = mtfkt_pkg::STS_BAD_POS;
          state_next      = mtfkt_pkg::S_RESP;
        end
      end
      mtfkt_pkg::S_READ_WAIT: begin
        cmd.read_take = 1'b1;
        state_next    = mtfkt_pkg::S_RESP;
      end
      mtfkt_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = mtfkt_pkg::S_IDLE;
        end
      end
      default: state_next = mtfkt_pkg::S_IDLE;
    endcase
  end

endmodule

@@ src/mtfkt_dpath.sv @@
module mtfkt_dpath #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [63:0]      key,
  input  logic [3:0]       position,
  input  mtfkt_pkg::cmd_t  cmd,
  output mtfkt_pkg::sts_t  sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       status,
  output logic [3:0]       found_at,
  output logic [63:0]      read_key,
  output logic [4:0]       entry_count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Entry storage: one write port, one registered read port.
  logic [KEY_WIDTH-1:0] mem [DEPTH];
  logic [KEY_WIDTH-1:0] rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  // Request and working registers.
  logic [KEY_WIDTH-1:0] key_r;
  logic [3:0]           pos_r;
  logic [CW-1:0]        count;
  logic [CW-1:0]        scan_addr;
  logic [AW-1:0]        cmp_idx;
  logic                 rd_pend;
  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        wr_ptr;
  logic                 rd_more;
  mtfkt_pkg::status_t   res_status;
  logic [3:0]           res_found;
  logic [KEY_WIDTH-1:0] res_rkey;

  logic scan_issue;

  assign scan_issue = scan_addr < count;

  always_comb begin
    sts.full       = count == CW'(DEPTH);
    sts.pos_ok     = 32'(pos_r) < 32'(count);
    sts.scan_hit   = rd_pend && (rdata == key_r);
    sts.scan_miss  = !scan_issue && !rd_pend;
    sts.hit_front  = cmp_idx == '0;
    sts.shift_done = !rd_more && !rd_pend;
    sts.out_free   = !out_valid || !out_stall;
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = key_r;
    mem_re    = 1'b0;
    mem_raddr = '0;
    priority if (cmd.append) begin
      mem_we    = 1'b1;
      mem_waddr = count[AW-1:0];
    end else if (cmd.shift_run && rd_pend) begin
      mem_we    = 1'b1;
      mem_waddr = wr_ptr;
      mem_wdata = rdata;
    end else if (cmd.front_write) begin
      mem_we    = 1'b1;
    end
    priority if (cmd.scan_run && scan_issue) begin
      mem_re    = 1'b1;
      mem_raddr = scan_addr[AW-1:0];
    end else if (cmd.shift_run && rd_more) begin
      mem_re    = 1'b1;
      mem_raddr = rd_ptr;
    end else if (cmd.read_issue) begin
      mem_re    = 1'b1;
      mem_raddr = AW'(pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r      <= key[KEY_WIDTH-1:0];
      pos_r      <= position;
      res_status <= mtfkt_pkg::STS_OK;
      res_found  <= '0;
      res_rkey   <= '0;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
    if (cmd.scan_init) begin
      scan_addr <= '0;
    end
    if (cmd.scan_run) begin
      cmp_idx <= scan_addr[AW-1:0];
      if (scan_issue) begin
        scan_addr <= scan_addr + CW'(1);
      end
    end
    if (cmd.hit_take) begin
      res_found <= 4'(cmp_idx);
      wr_ptr    <= cmp_idx;
      rd_ptr    <= cmp_idx - AW'(1);
    end
    if (cmd.shift_run) begin
      if (rd_pend) begin
        wr_ptr <= wr_ptr - AW'(1);
      end
      if (rd_more && (rd_ptr != '0)) begin
        rd_ptr <= rd_ptr - AW'(1);
      end
    end
    if (cmd.read_take) begin
      res_rkey <= rdata;
    end
    if (cmd.out_load) begin
      status      <= res_status;
      found_at    <= res_found;
      read_key    <= 64'(res_rkey);
      entry_count <= 5'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_pend   <= 1'b0;
      rd_more   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.append) begin
        count <= count + CW'(1);
      end
      if (cmd.scan_init || cmd.hit_take) begin
        rd_pend <= 1'b0;
      end else if (cmd.scan_run) begin
        rd_pend <= scan_issue;
      end else if (cmd.shift_run) begin
        rd_pend <= rd_more;
      end
      if (cmd.hit_take) begin
        rd_more <= 1'b1;
      end else if (cmd.shift_run && rd_more && (rd_ptr == '0)) begin
        rd_more <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/move_to_front_key_table_top.sv @@
// Move-to-front key table. The block keeps an ordered list of up to DEPTH keys of
// KEY_WIDTH bits (position 0 is the front) and serves one request per input
// transaction, answering each with exactly one output transaction. An append
// puts the key at the tail, or reports a full table and drops it. A search walks
// the list from the front, and on the first match moves that entry to the front
// while the entries ahead of it slide back by one; found_at reports where it was.
// A read returns the key at a position, or reports a position at or beyond the
// count. Requests are served one at a time: an entry memory with one write port
// and one registered read port sets the pace. A search does one read per entry
// during the scan, then one read and one write per entry during the shift,
// overlapped; a search whose key is already at the front skips the shift.
// The result sits in an output register, so a new request is accepted while the
// previous result waits to be taken. Reset empties the table; entry contents are
// not cleared and are never visible before being written.
module move_to_front_key_table_top #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [63:0] key,
  input  logic [3:0]  position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  found_at,
  output logic [63:0] read_key,
  output logic [4:0]  entry_count
);

  // The controller sequences each request; the datapath holds the table,
  // the scan and shift pointers and the output register.
  mtfkt_pkg::cmd_t cmd;
  mtfkt_pkg::sts_t sts;

  mtfkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtfkt_dpath #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .key         (key),
    .position    (position),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .found_at    (found_at),
    .read_key    (read_key),
    .entry_count (entry_count)
  );

endmodule
